FILE: rtl/tbm_pkg.sv
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared sizes, codes, word types and helpers of the binary trie multiset.
// ----------------------------------------------------------------------------
package tbm_pkg;

    localparam int KEY_BITS   = 10;
    localparam int COUNT_BITS = 16;

    // node index: root 0, children of n are 2n+1 and 2n+2
    localparam int NODE_BITS  = KEY_BITS + 1;
    localparam int NODE_DEPTH = 2 ** NODE_BITS;
    localparam int LVL_BITS   = $clog2(KEY_BITS + 1);
    localparam int WIDE_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [LVL_BITS-1:0]   t_lvl;
    typedef logic [WIDE_BITS-1:0]  t_wide;

    localparam t_count COUNT_MAX = '1;
    localparam t_node  LEAF_BASE = t_node'((2 ** KEY_BITS) - 1);
    localparam t_lvl   LVL_LAST  = t_lvl'(KEY_BITS - 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_COUNT  = 2'd2;
    localparam logic [1:0] OP_KTH    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  key;
        logic [15:0] rank;
    } t_cmd;

    typedef struct packed {
        logic [15:0] result_value;
        logic [1:0]  status;
        logic [15:0] total_size;
    } t_result;

    function automatic logic [15:0] sat16(t_count v);
        t_wide w;
        w = t_wide'(v);
        if (w > t_wide'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return 16'(w);
    endfunction

endpackage

FILE: rtl/tbm_ram.sv
// ----------------------------------------------------------------------------
// tbm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/binary_trie_multiset.sv
// ----------------------------------------------------------------------------
// binary_trie_multiset
// Multiset of keys held as a binary tree of occurrence counters in one RAM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  command   in         start high, busy low   i_cmd  (operation, key, rank)
//  result    out        o_done, one cycle      o_result (value, status, total)
//
//  insert and erase do one counter read-modify-write per tree level; erase
//  and count first read the leaf, k-th walks down from the root. a refused
//  insert or an out-of-range rank answers straight from idle, with no RAM read.
//  after reset a clearing pass writes 2^(KEY_BITS+1) entries, one per cycle,
//  with busy high; the root count lives in a register, not in the RAM.
//  results cannot be stalled: o_done marks each word for one cycle.
// ----------------------------------------------------------------------------
module binary_trie_multiset (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tbm_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output tbm_pkg::t_result o_result
);
    import tbm_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LEAF  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_KTH   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_op,    n_op;
    t_node       r_node,  n_node;
    t_lvl        r_lvl,   n_lvl;
    t_key        r_path,  n_path;
    t_key        r_found, n_found;
    logic [15:0] r_rank,  n_rank;
    t_count      r_total, n_total;
    t_node       r_clr,   n_clr;
    logic        r_done,  n_done;
    t_result     r_res,   n_res;

    logic   ram_we;
    t_node  ram_waddr;
    t_count ram_wdata;
    t_node  ram_raddr;
    logic   ram_re;
    t_count ram_rdata;

    t_key   in_key;
    logic   go_right;
    t_node  child;

    tbm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NODE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_key   = t_key'(i_cmd.key);
    assign go_right = !(t_wide'(r_rank) < t_wide'(ram_rdata));
    assign child    = r_node + t_node'(go_right);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_node    = r_node;
        n_lvl     = r_lvl;
        n_path    = r_path;
        n_found   = r_found;
        n_rank    = r_rank;
        n_total   = r_total;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = '0;
        ram_raddr = '0;
        ram_re    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + t_node'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op    = i_cmd.operation;
                    n_lvl   = '0;
                    n_found = '0;
                    n_rank  = i_cmd.rank;
                    n_res   = '{result_value: 16'd0, status: ST_OK,
                                total_size: sat16(r_total)};
                    case (i_cmd.operation)
                        OP_INSERT: begin
                            if (r_total == COUNT_MAX) begin
                                n_res.status = ST_FULL;
                                n_done       = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = t_node'(1) + t_node'(in_key[KEY_BITS-1]);
                                n_node    = ram_raddr;
                                n_path    = in_key << 1;
                                n_state   = S_WALK;
                            end
                        end
                        OP_ERASE, OP_COUNT: begin
                            ram_re    = 1'b1;
                            ram_raddr = LEAF_BASE + t_node'(in_key);
                            n_path    = in_key;
                            n_state   = S_LEAF;
                        end
                        default: begin
                            if (t_wide'(i_cmd.rank) >= t_wide'(r_total)) begin
                                n_res.status = ST_RANGE;
                                n_done       = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = t_node'(1);
                                n_node    = t_node'(1);
                                n_state   = S_KTH;
                            end
                        end
                    endcase
                end
            end
            S_LEAF: begin
                if (r_op == OP_COUNT) begin
                    n_res.result_value = sat16(ram_rdata);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (ram_rdata == '0) begin
                    n_res.status = ST_ABSENT;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = t_node'(1) + t_node'(r_path[KEY_BITS-1]);
                    n_node    = ram_raddr;
                    n_path    = r_path << 1;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                // write back this level while the next level is read
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = (r_op == OP_INSERT) ? ram_rdata + t_count'(1)
                                                : ram_rdata - t_count'(1);
                if (r_lvl == LVL_LAST) begin
                    n_total = (r_op == OP_INSERT) ? r_total + t_count'(1)
                                                  : r_total - t_count'(1);
                    n_res.total_size = sat16(n_total);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = (r_node << 1) + t_node'(1) + t_node'(r_path[KEY_BITS-1]);
                    n_node    = ram_raddr;
                    n_path    = r_path << 1;
                    n_lvl     = r_lvl + t_lvl'(1);
                end
            end
            S_KTH: begin
                // ram_rdata is the left subtree count below the current node
                n_found = (r_found << 1) | t_key'(go_right);
                if (go_right) begin
                    n_rank = r_rank - 16'(ram_rdata);
                end
                if (r_lvl == LVL_LAST) begin
                    n_res.result_value = 16'(n_found);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = (child << 1) + t_node'(1);
                    n_node    = ram_raddr;
                    n_lvl     = r_lvl + t_lvl'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_node  <= n_node;
        r_lvl   <= n_lvl;
        r_path  <= n_path;
        r_found <= n_found;
        r_rank  <= n_rank;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result word during clearing pass");

    a_total_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != $past(r_total)) |-> r_done)
        else $error("total changed without a result word");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same node in one cycle");

    a_full_only_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (r_total == COUNT_MAX))
        else $error("full status below maximum total");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the binary trie multiset against an in-bench counter tree. A short
// set of directed commands covers the empty set, the key extremes, refused
// erases and out-of-range ranks. Random traffic follows, built mostly from
// legal sequences: erases and counts of held keys, and ranks below the size.
// A closing set of corner commands runs with no idle cycles.
// Results are checked field by field, in order, at every o_done.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tbm_pkg::*;

    localparam int RANDOM_CMDS = 1650;
    localparam int MAX_REPORTS = 100;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    logic    o_done;
    t_result o_result;

    t_cmd    cmd_backlog[$];
    t_result want_results[$];
    t_key    key_bag[$];
    t_count  trie_cnt [0:NODE_DEPTH-2];

    logic    cmd_taken = 1'b0;
    int      taken_cnt = 0;
    int      fill_from = 0;
    int      mismatch_cnt = 0;

    binary_trie_multiset uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // update every counter along the key's path, root to leaf
    function automatic void trie_walk(t_key k, bit up);
        int node;
        int lvl;
        node = 0;
        for (lvl = KEY_BITS - 1; lvl >= -1; lvl--) begin
            if (up) begin
                trie_cnt[node] = trie_cnt[node] + 1'b1;
            end else begin
                trie_cnt[node] = trie_cnt[node] - 1'b1;
            end
            if (lvl >= 0) begin
                node = 2 * node + 1 + int'(k[lvl]);
            end
        end
    endfunction

    function automatic t_result trie_apply(t_cmd c);
        t_result     r;
        int          leaf;
        int          node;
        int          lvl;
        logic [15:0] rk;
        t_key        found;
        t_count      left;
        r = '0;
        leaf = int'(LEAF_BASE) + int'(c.key);
        case (c.operation)
            OP_INSERT: begin
                if (trie_cnt[0] == COUNT_MAX) begin
                    r.status = ST_FULL;
                end else begin
                    trie_walk(c.key, 1'b1);
                end
            end
            OP_ERASE: begin
                if (trie_cnt[leaf] == '0) begin
                    r.status = ST_ABSENT;
                end else begin
                    trie_walk(c.key, 1'b0);
                end
            end
            OP_COUNT: begin
                r.result_value = 16'(trie_cnt[leaf]);
            end
            default: begin
                if (c.rank >= trie_cnt[0]) begin
                    r.status = ST_RANGE;
                end else begin
                    rk = c.rank;
                    node = 0;
                    found = '0;
                    // go left while the rank falls inside the left subtree
                    for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                        left = trie_cnt[2 * node + 1];
                        if (rk < left) begin
                            node = 2 * node + 1;
                        end else begin
                            rk = rk - left;
                            node = 2 * node + 2;
                            found[lvl] = 1'b1;
                        end
                    end
                    r.result_value = 16'(found);
                end
            end
        endcase
        r.total_size = 16'(trie_cnt[0]);
        return r;
    endfunction

    // queue a command and keep the bag of held keys in step for later picks
    task automatic add_cmd(logic [1:0] op, t_key key, logic [15:0] rank);
        t_cmd c;
        int   idx;
        c.operation = op;
        c.key = key;
        c.rank = rank;
        cmd_backlog.push_back(c);
        if (op == OP_INSERT && key_bag.size() < int'(COUNT_MAX)) begin
            key_bag.push_back(key);
        end else if (op == OP_ERASE) begin
            idx = 0;
            while (idx < key_bag.size() && key_bag[idx] != key) begin
                idx++;
            end
            if (idx < key_bag.size()) begin
                key_bag.delete(idx);
            end
        end
    endtask

    function automatic t_key pick_key(t_key hot_keys[8]);
        if ($urandom_range(1) == 0) begin
            return hot_keys[$urandom_range(7)];
        end
        return t_key'($urandom_range(1023));
    endfunction

    function automatic t_key held_or_any(t_key hot_keys[8]);
        if (key_bag.size() != 0 && $urandom_range(9) < 8) begin
            return key_bag[$urandom_range(key_bag.size() - 1)];
        end
        return pick_key(hot_keys);
    endfunction

    // driver: accept on the rising edge, present words on the falling edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= start && !busy;
            if (start && !busy) begin
                want_results.push_back(trie_apply(i_cmd));
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (cmd_backlog.size() != 0 &&
                ((taken_cnt >= 700 && taken_cnt < 1000) || taken_cnt >= fill_from ||
                 $urandom_range(99) >= 14)) begin
                start <= 1'b1;
                i_cmd <= cmd_backlog.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_done) begin
            if (want_results.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < MAX_REPORTS) begin
                    $error("result word with no command waiting: value %0d status %0d size %0d",
                           o_result.result_value, o_result.status, o_result.total_size);
                end
            end else begin
                exp_r = want_results.pop_front();
                if (o_result !== exp_r) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < MAX_REPORTS) begin
                        if (o_result.result_value !== exp_r.result_value) begin
                            $error("result_value: expected %0d, got %0d",
                                   exp_r.result_value, o_result.result_value);
                        end
                        if (o_result.status !== exp_r.status) begin
                            $error("status: expected %0d, got %0d",
                                   exp_r.status, o_result.status);
                        end
                        if (o_result.total_size !== exp_r.total_size) begin
                            $error("total_size: expected %0d, got %0d",
                                   exp_r.total_size, o_result.total_size);
                        end
                    end
                end
            end
        end
    end

    initial begin
        t_key hot_keys[8];
        int   n;
        int   pick;
        foreach (trie_cnt[i]) begin
            trie_cnt[i] = '0;
        end
        foreach (hot_keys[i]) begin
            hot_keys[i] = t_key'($urandom_range(1023));
        end
        fill_from = 1 << 30;

        // empty set, key extremes, refused erases and ranks
        add_cmd(OP_COUNT, 10'd0, 16'd0);
        add_cmd(OP_ERASE, 10'd0, 16'hFFFF);
        add_cmd(OP_KTH, 10'd1023, 16'd0);
        add_cmd(OP_KTH, 10'd0, 16'hFFFF);
        add_cmd(OP_INSERT, 10'd0, 16'd0);
        add_cmd(OP_INSERT, 10'd1023, 16'hFFFF);
        add_cmd(OP_INSERT, 10'd1023, 16'd0);
        add_cmd(OP_INSERT, 10'd512, 16'd0);
        add_cmd(OP_INSERT, 10'd511, 16'd0);
        add_cmd(OP_COUNT, 10'd1023, 16'd0);
        add_cmd(OP_COUNT, 10'd0, 16'd0);
        add_cmd(OP_COUNT, 10'd5, 16'd0);
        for (n = 0; n <= 5; n++) begin
            add_cmd(OP_KTH, 10'h2AA, 16'(n));
        end
        add_cmd(OP_ERASE, 10'd1023, 16'd0);
        add_cmd(OP_ERASE, 10'd1023, 16'd0);
        add_cmd(OP_ERASE, 10'd1023, 16'd0);
        add_cmd(OP_ERASE, 10'd0, 16'd0);
        add_cmd(OP_ERASE, 10'd512, 16'd0);
        add_cmd(OP_ERASE, 10'd511, 16'd0);

        // random traffic, mostly legal
        for (n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 36) begin
                add_cmd(OP_INSERT, pick_key(hot_keys), 16'($urandom));
            end else if (pick < 60) begin
                add_cmd(OP_ERASE, held_or_any(hot_keys), 16'($urandom));
            end else if (pick < 78) begin
                add_cmd(OP_COUNT, held_or_any(hot_keys), 16'($urandom));
            end else if (key_bag.size() != 0 && $urandom_range(9) < 8) begin
                add_cmd(OP_KTH, t_key'($urandom),
                        16'($urandom_range(key_bag.size() - 1)));
            end else begin
                add_cmd(OP_KTH, t_key'($urandom), 16'($urandom));
            end
        end

        // closing corner cases, driven with no idle cycles
        fill_from = cmd_backlog.size();
        add_cmd(OP_INSERT, 10'd5, 16'd0);
        add_cmd(OP_COUNT, 10'd1023, 16'd0);
        add_cmd(OP_KTH, 10'd0, 16'hFFFE);
        add_cmd(OP_KTH, 10'd0, 16'hFFFF);
        add_cmd(OP_KTH, 10'd0, 16'd0);
        add_cmd(OP_ERASE, 10'd1023, 16'd0);
        add_cmd(OP_INSERT, 10'd0, 16'd0);
        add_cmd(OP_INSERT, 10'd7, 16'd0);
        add_cmd(OP_COUNT, 10'd0, 16'd0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start || want_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // timeout: stop the run and report mismatches if it has not finished
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
